@@ src/deq_pkg.sv @@
// Package for the double-ended queue core: payload structs, codes, FSM states
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

   localparam int DEQ_CAPACITY = 16;
   localparam int DATA_W       = 32;
   localparam int OP_W         = 3;
   localparam int STATUS_W     = 2;
   localparam int COUNT_OUT_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_CLEAR      = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type                   op;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] removed_value;
      logic [COUNT_OUT_W-1:0]   item_count;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_READ = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic execute;
      logic read_done;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pop_hit;
   } dp_stat_type;

endpackage

@@ src/deq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/deq_ctrl.sv @@
// Controller state machine of the double-ended queue core.
// Depends on deq_pkg for the state enum and the command/status structs.
`timescale 1ns / 1ps

module deq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output deq_pkg::ctrl_cmd_type cmd,
   input  deq_pkg::dp_stat_type  stat
);
   import deq_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            // A successful pop goes on to S_READ for the registered RAM read.
            state_in = stat.pop_hit ? S_READ : S_IDLE;
         end
         S_READ: begin
            cmd.read_done = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ src/deq_datapath.sv @@
// Datapath of the double-ended queue core: request register, ring indices,
// item count, ring store and result register.
// Depends on deq_pkg and deq_ram.
`timescale 1ns / 1ps

module deq_datapath #(
   parameter int CAPACITY = deq_pkg::DEQ_CAPACITY
) (
   input  logic                  clock,
   input  logic                  reset,
   input  deq_pkg::req_type      req_data,
   input  deq_pkg::ctrl_cmd_type cmd,
   output deq_pkg::dp_stat_type  stat,
   output logic                  rsp_valid,
   output deq_pkg::rsp_type      rsp_data
);
   import deq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = CNT_W + 1;

   req_type          req_ff;
   logic [IDX_W-1:0] front_ff;
   logic [IDX_W-1:0] front_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic                   full;
   logic                   empty;
   logic                   is_push;
   logic                   is_pop;
   logic [IDX_W-1:0]       front_dec;
   logic [IDX_W-1:0]       front_inc;
   logic [SUM_W-1:0]       back_raw;
   logic [SUM_W-1:0]       last_raw;
   logic [IDX_W-1:0]       back_idx;
   logic [IDX_W-1:0]       last_idx;
   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   logic                   ram_re;
   logic [IDX_W-1:0]       ram_raddr;
   logic [DATA_W-1:0]      ram_rdata;
   logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign is_push = (req_ff.op == OP_PUSH_FRONT) || (req_ff.op == OP_PUSH_BACK);
   assign is_pop  = (req_ff.op == OP_POP_FRONT) || (req_ff.op == OP_POP_BACK);
   assign stat.pop_hit = is_pop && !empty;

   assign front_dec = (front_ff == '0) ? IDX_W'(CAPACITY - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == IDX_W'(CAPACITY - 1)) ? '0 : front_ff + 1'b1;

   // Both sums stay below twice the capacity, so one conditional subtract wraps them.
   assign back_raw = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign last_raw = back_raw - 1'b1;
   assign back_idx = (back_raw >= SUM_W'(CAPACITY))
                     ? IDX_W'(back_raw - SUM_W'(CAPACITY)) : IDX_W'(back_raw);
   assign last_idx = (last_raw >= SUM_W'(CAPACITY))
                     ? IDX_W'(last_raw - SUM_W'(CAPACITY)) : IDX_W'(last_raw);

   assign ram_we    = cmd.execute && is_push && !full;
   assign ram_waddr = (req_ff.op == OP_PUSH_FRONT) ? front_dec : back_idx;
   assign ram_re    = cmd.execute && stat.pop_hit;
   assign ram_raddr = (req_ff.op == OP_POP_FRONT) ? front_ff : last_idx;

   deq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ring_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_ff.value),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      front_in     = front_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (cmd.execute) begin
         rsp_in.status        = STATUS_OK;
         rsp_in.removed_value = '0;
         case (req_ff.op)
            OP_PUSH_FRONT: begin
               if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  front_in = front_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_PUSH_BACK: begin
               if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  rsp_in.status = STATUS_EMPTY;
               end else begin
                  front_in = front_inc;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  rsp_in.status = STATUS_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            OP_CLEAR: begin
               front_in = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
         count_ext          = {{COUNT_OUT_W{1'b0}}, count_in};
         rsp_in.item_count  = count_ext[COUNT_OUT_W-1:0];
         // A successful pop reports once the read data is back.
         rsp_valid_in       = !stat.pop_hit;
      end else if (cmd.read_done) begin
         count_ext            = {{COUNT_OUT_W{1'b0}}, count_ff};
         rsp_in.status        = STATUS_OK;
         rsp_in.removed_value = ram_rdata;
         rsp_in.item_count    = count_ext[COUNT_OUT_W-1:0];
         rsp_valid_in         = 1'b1;
      end else begin
         count_ext = {{COUNT_OUT_W{1'b0}}, count_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("item count exceeds capacity");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff <= IDX_W'(CAPACITY - 1))
      else $error("front index out of range");

   a_full_push_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && is_push && full) |=> $stable(count_ff) && $stable(front_ff))
      else $error("push on a full queue changed the state");

   a_removed_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.removed_value != '0) |-> rsp_ff.status == STATUS_OK)
      else $error("nonzero removed value with a failing status");

endmodule

@@ src/double_ended_queue_core.sv @@
// Top level of the bounded double-ended queue held in a ring store.
// Depends on deq_pkg, deq_ctrl, deq_datapath (which holds deq_ram).
//
//   channel   ports                        direction  handshake
//   request   start, busy, req_data        in         start && !busy
//   response  rsp_valid, rsp_data          out        rsp_valid, one cycle
//
// A push, a clear, an unused op code or a pop on an empty queue runs through S_EXEC
// alone; a successful pop also runs through S_READ, for the registered read of the
// ring store RAM. The result strobe follows the last cycle of the transaction.
// Synchronous reset empties the queue; the ring store itself is not cleared.
// The receiver cannot stall, so the response register simply drives for one cycle.
`timescale 1ns / 1ps

module double_ended_queue_core #(
   parameter int CAPACITY = deq_pkg::DEQ_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  deq_pkg::req_type req_data,
   output logic             rsp_valid,
   output deq_pkg::rsp_type rsp_data
);
   import deq_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   deq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   deq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/double_ended_queue_core_tb.sv @@
// Self-checking testbench for double_ended_queue_core: a shadow deque predicts every
// outcome, directed corner cases come first, then random traffic under sender idling.
// Depends on deq_pkg and the double_ended_queue_core RTL.
`timescale 1ns / 1ps

module double_ended_queue_core_tb;
   import deq_pkg::*;

   localparam int          CAP            = DEQ_CAPACITY;
   localparam int          CYCLE_LIMIT    = 200000;
   localparam int          REPORT_LIMIT   = 10;
   localparam int          DRAIN_CYCLES   = 8;
   localparam int          PHASE_ITEMS    = 460;
   localparam logic [2:0]  FIRST_UNUSED_OP = 3'd5;
   localparam logic [2:0]  LAST_UNUSED_OP  = 3'd7;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Shadow copy of the deque contents and indexes.
   logic signed [DATA_W-1:0] shadow_ring [CAP];
   int                       shadow_head;
   int                       shadow_fill;

   rsp_type queued_outcomes [$];
   int      mismatch_count;
   int      cycle_count;

   double_ended_queue_core #(.CAPACITY(CAP)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("double_ended_queue_core verification failed");
         $finish;
      end
   end

   // Applies one request to the shadow deque and returns the outcome it must produce.
   function automatic rsp_type deque_apply(req_type r);
      rsp_type o;
      o.status        = STATUS_OK;
      o.removed_value = '0;
      case (r.op)
         OP_PUSH_FRONT: begin
            if (shadow_fill >= CAP) begin
               o.status = STATUS_FULL;
            end else begin
               shadow_head = (shadow_head + CAP - 1) % CAP;
               shadow_ring[shadow_head] = r.value;
               shadow_fill++;
            end
         end
         OP_PUSH_BACK: begin
            if (shadow_fill >= CAP) begin
               o.status = STATUS_FULL;
            end else begin
               shadow_ring[(shadow_head + shadow_fill) % CAP] = r.value;
               shadow_fill++;
            end
         end
         OP_POP_FRONT: begin
            if (shadow_fill == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               o.removed_value = shadow_ring[shadow_head];
               shadow_head = (shadow_head + 1) % CAP;
               shadow_fill--;
            end
         end
         OP_POP_BACK: begin
            if (shadow_fill == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               o.removed_value = shadow_ring[(shadow_head + shadow_fill - 1) % CAP];
               shadow_fill--;
            end
         end
         OP_CLEAR: begin
            shadow_fill = 0;
            shadow_head = 0;
         end
         default: ;
      endcase
      o.item_count = COUNT_OUT_W'(shadow_fill);
      return o;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endtask

   // Each outcome is valid for exactly one cycle; it is taken at the edge ending it.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (queued_outcomes.size() == 0) begin
            note_mismatch($sformatf("unexpected outcome %p", rsp_data));
         end else begin
            want = queued_outcomes.pop_front();
            if (rsp_data.status !== want.status)
               note_mismatch($sformatf("status expected %0d got %0d",
                                       want.status, rsp_data.status));
            if (rsp_data.removed_value !== want.removed_value)
               note_mismatch($sformatf("removed_value expected %0d got %0d",
                                       want.removed_value, rsp_data.removed_value));
            if (rsp_data.item_count !== want.item_count)
               note_mismatch($sformatf("item_count expected %0d got %0d",
                                       want.item_count, rsp_data.item_count));
         end
      end
   end

   // Holds a request on the port until the core takes it, then predicts its outcome.
   task automatic send_request(input op_type op, input logic signed [DATA_W-1:0] value);
      req_type r;
      r.op    = op;
      r.value = value;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      queued_outcomes.push_back(deque_apply(r));
   endtask

   task automatic maybe_idle(input int idle_pct);
      if ($urandom_range(1, 100) <= idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom();
      endcase
   endfunction

   task automatic test_empty_pops();
      send_request(OP_POP_FRONT, 32'sh1234_5678);
      send_request(OP_POP_BACK, -32'sd1);
   endtask

   // Fills the deque from both ends, wrapping the front index below zero,
   // then checks that further pushes at either end are refused.
   task automatic test_fill_and_overflow();
      send_request(OP_PUSH_FRONT, 32'sh8000_0000);
      send_request(OP_PUSH_BACK, 32'sh7fff_ffff);
      send_request(OP_PUSH_FRONT, -32'sd1);
      send_request(OP_PUSH_BACK, '0);
      for (int i = 4; i < CAP; i++)
         send_request((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom());
      send_request(OP_PUSH_FRONT, 32'sh5555_5555);
      send_request(OP_PUSH_BACK, 32'shaaaa_aaaa);
   endtask

   task automatic test_pops_from_both_ends();
      send_request(OP_POP_FRONT, '0);
      send_request(OP_POP_BACK, '0);
   endtask

   task automatic test_unused_ops_and_clear();
      send_request(op_type'(FIRST_UNUSED_OP), -32'sd1);
      send_request(op_type'(LAST_UNUSED_OP), 32'sh7fff_ffff);
      send_request(OP_CLEAR, 32'sh8000_0000);
      send_request(OP_POP_BACK, '0);
   endtask

   // Random traffic in bursts that lean toward filling, draining or neither, so the
   // count sweeps between empty and full; a few clears and unused codes are mixed in.
   task automatic test_random_traffic(input int idle_pct, input int items);
      int     sent;
      int     burst_len;
      int     lean;
      int     burst_idle;
      int     roll;
      op_type op;
      sent = 0;
      while (sent < items) begin
         burst_len  = $urandom_range(5, 40);
         lean       = $urandom_range(0, 2);
         burst_idle = ($urandom_range(0, 3) == 0) ? 0 : idle_pct;
         for (int i = 0; i < burst_len && sent < items; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
               op = OP_CLEAR;
            end else if (roll < 4) begin
               op = op_type'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP));
            end else begin
               roll = $urandom_range(0, 99);
               case (lean)
                  0:       op = (roll < 75) ? OP_PUSH_FRONT : OP_POP_FRONT;
                  1:       op = (roll < 25) ? OP_PUSH_BACK : OP_POP_BACK;
                  default: op = (roll < 50) ? OP_PUSH_BACK : OP_POP_FRONT;
               endcase
               // Either end is used in every lean.
               if ($urandom_range(0, 1)) begin
                  case (op)
                     OP_PUSH_FRONT: op = OP_PUSH_BACK;
                     OP_PUSH_BACK:  op = OP_PUSH_FRONT;
                     OP_POP_FRONT:  op = OP_POP_BACK;
                     OP_POP_BACK:   op = OP_POP_FRONT;
                     default: ;
                  endcase
               end
            end
            send_request(op, pick_value());
            sent++;
            maybe_idle(burst_idle);
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      shadow_head    = 0;
      shadow_fill    = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_empty_pops();
      test_fill_and_overflow();
      test_pops_from_both_ends();
      test_unused_ops_and_clear();
      test_random_traffic(0, PHASE_ITEMS);
      test_random_traffic(61, PHASE_ITEMS);
      test_random_traffic(15, PHASE_ITEMS);

      start <= 1'b0;
      while (queued_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("double_ended_queue_core verification clean");
      end else begin
         $display("double_ended_queue_core verification failed");
      end
      $finish;
   end

endmodule
